// ----- sv/isl_pkg.sv -----
// isl_pkg: types, codes and command/status structs for indexed_shift_list.
// Used by isl_ctrl, isl_datapath and indexed_shift_list; no dependencies.
package isl_pkg;

   localparam int CAPACITY_DEF = 64;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_INSERT = 2'd2,
      OP_REMOVE = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      RA_IDX_DN,
      RA_IDX_UP,
      RA_POS,
      RA_LAST
   } rd_sel_type;

   typedef enum logic [1:0] {
      WA_IDX,
      WA_POS,
      WA_LEN
   } wr_sel_type;

   typedef enum logic {
      WS_VALUE,
      WS_READ
   } wr_src_type;

   typedef enum logic [2:0] {
      IX_HOLD,
      IX_LEN,
      IX_POS,
      IX_DEC,
      IX_INC
   } idx_op_type;

   typedef enum logic [1:0] {
      LN_HOLD,
      LN_INC,
      LN_DEC
   } len_op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECIDE,
      S_POP_TAKE,
      S_INS_CHK,
      S_INS_WR,
      S_REM_TAKE,
      S_REM_CHK,
      S_REM_WR,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       latch;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_en;
      wr_sel_type wr_sel;
      wr_src_type wr_src;
      idx_op_type idx_op;
      len_op_type len_op;
      logic       take_en;
      logic       status_en;
      status_type status;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   empty;
      logic   full;
      logic   pos_gt_len;
      logic   pos_ge_len;
      logic   idx_gt_pos;
      logic   idx_up_lt_len;
   } stat_type;

endpackage

// ----- sv/isl_datapath.sv -----
// isl_datapath: element memory, length, cursor and result registers.
// Driven by isl_ctrl through isl_pkg::cmd_type; depends on isl_pkg.
module isl_datapath #(
   parameter int CAPACITY = isl_pkg::CAPACITY_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  isl_pkg::cmd_type    cmd,
   output isl_pkg::stat_type   stat,
   input  logic [1:0]          req_op,
   input  logic signed [31:0]  req_value,
   input  logic [6:0]          req_position,
   output logic signed [31:0]  rsp_taken,
   output logic [1:0]          rsp_status,
   output logic [6:0]          rsp_count
);

   localparam int LW = $clog2(CAPACITY + 1);
   localparam int AW = $clog2(CAPACITY);
   localparam int CW = (LW > 7) ? LW : 7;

   logic [31:0] mem [CAPACITY];

   isl_pkg::op_type     op_ff, op_in;
   logic signed [31:0]  value_ff, value_in;
   logic [6:0]          pos_ff, pos_in;
   logic [LW-1:0]       length_ff, length_in;
   logic [LW-1:0]       idx_ff, idx_in;
   logic signed [31:0]  taken_ff, taken_in;
   isl_pkg::status_type status_ff, status_in;
   logic [31:0]         rd_data_ff;

   logic [CW-1:0] pos_ext, len_ext, idx_ext, count_ext;
   logic [LW-1:0] idx_up, rd_full, wr_full;
   logic [31:0]   wr_data;

   assign pos_ext   = CW'(pos_ff);
   assign len_ext   = CW'(length_ff);
   assign idx_ext   = CW'(idx_ff);
   assign idx_up    = idx_ff + LW'(1);

   assign stat.op            = op_ff;
   assign stat.empty         = (length_ff == '0);
   assign stat.full          = (length_ff == LW'(CAPACITY));
   assign stat.pos_gt_len    = (pos_ext > len_ext);
   assign stat.pos_ge_len    = (pos_ext >= len_ext);
   assign stat.idx_gt_pos    = (idx_ext > pos_ext);
   assign stat.idx_up_lt_len = (idx_up < length_ff);

   always_comb begin
      case (cmd.rd_sel)
         isl_pkg::RA_IDX_DN: rd_full = idx_ff - LW'(1);
         isl_pkg::RA_IDX_UP: rd_full = idx_up;
         isl_pkg::RA_POS:    rd_full = pos_ext[LW-1:0];
         isl_pkg::RA_LAST:   rd_full = length_ff - LW'(1);
         default:            rd_full = idx_ff;
      endcase
      case (cmd.wr_sel)
         isl_pkg::WA_IDX: wr_full = idx_ff;
         isl_pkg::WA_POS: wr_full = pos_ext[LW-1:0];
         isl_pkg::WA_LEN: wr_full = length_ff;
         default:         wr_full = idx_ff;
      endcase
      wr_data = (cmd.wr_src == isl_pkg::WS_READ) ? rd_data_ff : value_ff;
   end

   always_comb begin
      op_in     = op_ff;
      value_in  = value_ff;
      pos_in    = pos_ff;
      taken_in  = taken_ff;
      status_in = status_ff;
      if (cmd.latch) begin
         op_in    = isl_pkg::op_type'(req_op);
         value_in = req_value;
         pos_in   = req_position;
         taken_in = '0;
      end
      if (cmd.take_en) begin
         taken_in = rd_data_ff;
      end
      if (cmd.status_en) begin
         status_in = cmd.status;
      end
      case (cmd.idx_op)
         isl_pkg::IX_LEN: idx_in = length_ff;
         isl_pkg::IX_POS: idx_in = pos_ext[LW-1:0];
         isl_pkg::IX_DEC: idx_in = idx_ff - LW'(1);
         isl_pkg::IX_INC: idx_in = idx_up;
         default:         idx_in = idx_ff;
      endcase
      case (cmd.len_op)
         isl_pkg::LN_INC: length_in = length_ff + LW'(1);
         isl_pkg::LN_DEC: length_in = length_ff - LW'(1);
         default:         length_in = length_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
      end else begin
         length_ff <= length_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      value_ff  <= value_in;
      pos_ff    <= pos_in;
      idx_ff    <= idx_in;
      taken_ff  <= taken_in;
      status_ff <= status_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_full[AW-1:0]];
      end
      if (cmd.wr_en) begin
         mem[wr_full[AW-1:0]] <= wr_data;
      end
   end

   assign count_ext  = CW'(length_ff);
   assign rsp_taken  = taken_ff;
   assign rsp_status = status_ff;
   assign rsp_count  = count_ext[6:0];

endmodule

// ----- sv/isl_ctrl.sv -----
// isl_ctrl: request sequencer for indexed_shift_list.
// Issues isl_pkg::cmd_type to isl_datapath from its status; depends on isl_pkg.
module isl_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   input  isl_pkg::stat_type stat,
   output isl_pkg::cmd_type  cmd
);

   isl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= isl_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.rd_sel    = isl_pkg::RA_IDX_DN;
      cmd.wr_sel    = isl_pkg::WA_IDX;
      cmd.wr_src    = isl_pkg::WS_VALUE;
      cmd.idx_op    = isl_pkg::IX_HOLD;
      cmd.len_op    = isl_pkg::LN_HOLD;
      cmd.status    = isl_pkg::ST_OK;
      case (state_ff)
         isl_pkg::S_IDLE: begin
            if (start) begin
               cmd.latch = 1'b1;
               state_in  = isl_pkg::S_DECIDE;
            end
         end
         isl_pkg::S_DECIDE: begin
            cmd.status_en = 1'b1;
            state_in      = isl_pkg::S_DONE;
            case (stat.op)
               isl_pkg::OP_PUSH: begin
                  if (stat.full) begin
                     cmd.status = isl_pkg::ST_FULL;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.wr_sel = isl_pkg::WA_LEN;
                     cmd.len_op = isl_pkg::LN_INC;
                  end
               end
               isl_pkg::OP_POP: begin
                  if (stat.empty) begin
                     cmd.status = isl_pkg::ST_EMPTY;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = isl_pkg::RA_LAST;
                     state_in   = isl_pkg::S_POP_TAKE;
                  end
               end
               isl_pkg::OP_INSERT: begin
                  if (stat.pos_gt_len) begin
                     cmd.status = isl_pkg::ST_RANGE;
                  end else if (stat.full) begin
                     cmd.status = isl_pkg::ST_FULL;
                  end else begin
                     cmd.idx_op = isl_pkg::IX_LEN;
                     state_in   = isl_pkg::S_INS_CHK;
                  end
               end
               default: begin
                  if (stat.empty) begin
                     cmd.status = isl_pkg::ST_EMPTY;
                  end else if (stat.pos_ge_len) begin
                     cmd.status = isl_pkg::ST_RANGE;
                  end else begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = isl_pkg::RA_POS;
                     cmd.idx_op = isl_pkg::IX_POS;
                     state_in   = isl_pkg::S_REM_TAKE;
                  end
               end
            endcase
         end
         isl_pkg::S_POP_TAKE: begin
            cmd.take_en = 1'b1;
            cmd.len_op  = isl_pkg::LN_DEC;
            state_in    = isl_pkg::S_DONE;
         end
         isl_pkg::S_INS_CHK: begin
            if (stat.idx_gt_pos) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = isl_pkg::RA_IDX_DN;
               state_in   = isl_pkg::S_INS_WR;
            end else begin
               cmd.wr_en  = 1'b1;
               cmd.wr_sel = isl_pkg::WA_POS;
               cmd.wr_src = isl_pkg::WS_VALUE;
               cmd.len_op = isl_pkg::LN_INC;
               state_in   = isl_pkg::S_DONE;
            end
         end
         isl_pkg::S_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = isl_pkg::WA_IDX;
            cmd.wr_src = isl_pkg::WS_READ;
            cmd.idx_op = isl_pkg::IX_DEC;
            state_in   = isl_pkg::S_INS_CHK;
         end
         isl_pkg::S_REM_TAKE: begin
            cmd.take_en = 1'b1;
            state_in    = isl_pkg::S_REM_CHK;
         end
         isl_pkg::S_REM_CHK: begin
            if (stat.idx_up_lt_len) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = isl_pkg::RA_IDX_UP;
               state_in   = isl_pkg::S_REM_WR;
            end else begin
               cmd.len_op = isl_pkg::LN_DEC;
               state_in   = isl_pkg::S_DONE;
            end
         end
         isl_pkg::S_REM_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = isl_pkg::WA_IDX;
            cmd.wr_src = isl_pkg::WS_READ;
            cmd.idx_op = isl_pkg::IX_INC;
            state_in   = isl_pkg::S_REM_CHK;
         end
         isl_pkg::S_DONE: begin
            state_in = isl_pkg::S_IDLE;
         end
         default: begin
            state_in = isl_pkg::S_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != isl_pkg::S_IDLE);
   assign rsp_valid = (state_ff == isl_pkg::S_DONE);

endmodule

// ----- sv/indexed_shift_list.sv -----
// indexed_shift_list: ordered list with push, pop, insert and remove at index.
// Path to rsp_valid: push or a failed request runs S_DECIDE, S_DONE; pop adds
// S_POP_TAKE; insert loops S_INS_CHK/S_INS_WR and remove S_REM_CHK/S_REM_WR after
// S_REM_TAKE, each loop pass reading one element and writing it one place over.
// A new transaction is taken the cycle after rsp_valid; the receiver cannot stall.
// Reset (synchronous) clears the length and controller only; no clearing pass.
module indexed_shift_list #(
   parameter int CAPACITY = isl_pkg::CAPACITY_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic signed [31:0] req_value,
   input  logic [6:0]         req_position,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_taken,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_count
);

   isl_pkg::cmd_type  cmd;
   isl_pkg::stat_type stat;

   isl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .stat      (stat),
      .cmd       (cmd)
   );

   isl_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .req_op       (req_op),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_taken    (rsp_taken),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

`ifndef SYNTH
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("rsp_valid held longer than one cycle");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accepted transaction");

   a_fail_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != isl_pkg::ST_OK) |-> rsp_count == $past(rsp_count, 2))
      else $error("failed transaction changed the length");

   a_fail_taken: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != isl_pkg::ST_OK) |-> rsp_taken == 32'sd0)
      else $error("failed transaction returned a nonzero value");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
// tb_top: self-checking testbench for indexed_shift_list (push, pop, insert, remove).
// Needs isl_pkg and the indexed_shift_list RTL. A queue-fed driver sends requests
// and a monitor checks each response against a behavioral list model.
module tb_top;

   localparam int CAP = isl_pkg::CAPACITY_DEF;
   localparam int NUM_RANDOM = 730;
   localparam int CYCLE_LIMIT = 500000;
   localparam int DRAIN_CYCLES = 200;
   localparam int IDLE_PCT = 38;

   typedef struct {
      isl_pkg::op_type    op;
      logic signed [31:0] value;
      logic [6:0]         position;
   } req_item_type;

   typedef struct {
      logic signed [31:0]  taken;
      isl_pkg::status_type status;
      logic [6:0]          count;
   } rsp_item_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_op = '0;
   logic signed [31:0] req_value = '0;
   logic [6:0]         req_position = '0;
   logic               rsp_valid;
   logic signed [31:0] rsp_taken;
   logic [1:0]         rsp_status;
   logic [6:0]         rsp_count;

   req_item_type       pending_req[$];
   rsp_item_type       expected_rsp[$];
   logic signed [31:0] model_cells[CAP];
   int                 model_len = 0;
   int                 total_items = 0;
   int                 accepted_total = 0;
   int                 checked_total = 0;
   int                 error_count = 0;
   int                 cycle_count = 0;
   int                 peak_len = 0;
   int                 status_hits[4] = '{0, 0, 0, 0};
   int                 op_hits[4] = '{0, 0, 0, 0};
   logic               req_taken = 1'b0;

   indexed_shift_list #(.CAPACITY(CAP)) uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_taken    (rsp_taken),
      .rsp_status   (rsp_status),
      .rsp_count    (rsp_count)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic rsp_item_type list_apply(input req_item_type r);
      rsp_item_type o;
      int           i;
      o.taken  = '0;
      o.status = isl_pkg::ST_OK;
      case (r.op)
         isl_pkg::OP_PUSH: begin
            if (model_len >= CAP) begin
               o.status = isl_pkg::ST_FULL;
            end else begin
               model_cells[model_len] = r.value;
               model_len++;
            end
         end
         isl_pkg::OP_POP: begin
            if (model_len == 0) begin
               o.status = isl_pkg::ST_EMPTY;
            end else begin
               model_len--;
               o.taken = model_cells[model_len];
            end
         end
         isl_pkg::OP_INSERT: begin
            if (int'(r.position) > model_len) begin
               o.status = isl_pkg::ST_RANGE;
            end else if (model_len >= CAP) begin
               o.status = isl_pkg::ST_FULL;
            end else begin
               for (i = model_len; i > int'(r.position); i--)
                  model_cells[i] = model_cells[i - 1];
               model_cells[int'(r.position)] = r.value;
               model_len++;
            end
         end
         default: begin
            if (model_len == 0) begin
               o.status = isl_pkg::ST_EMPTY;
            end else if (int'(r.position) >= model_len) begin
               o.status = isl_pkg::ST_RANGE;
            end else begin
               o.taken = model_cells[int'(r.position)];
               model_len--;
               for (i = int'(r.position); i < model_len; i++)
                  model_cells[i] = model_cells[i + 1];
            end
         end
      endcase
      o.count = 7'(model_len);
      return o;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("MISMATCH at result %0d: %s got %0d expected %0d",
               checked_total, what, got, want);
      error_count++;
   endtask

   task automatic add_req(input isl_pkg::op_type op, input logic signed [31:0] value,
                          input int position);
      req_item_type r;
      r.op       = op;
      r.value    = value;
      r.position = 7'(position);
      pending_req.push_back(r);
      total_items++;
   endtask

   function automatic logic signed [31:0] pick_value();
      int sel;
      sel = $urandom_range(19);
      if (sel == 0) return 32'sh7FFF_FFFF;
      if (sel == 1) return 32'sh8000_0000;
      if (sel == 2) return '0;
      if (sel == 3) return -32'sd1;
      return $urandom;
   endfunction

   // Generator keeps only a length shadow so most positions land in range.
   task automatic build_random();
      int gen_len;
      int phase_left;
      int add_pct;
      int pos;
      int n;
      isl_pkg::op_type op;
      gen_len = 3;
      phase_left = 100;
      add_pct = 95;
      for (n = 0; n < NUM_RANDOM; n++) begin
         if (phase_left == 0) begin
            phase_left = $urandom_range(80, 20);
            case ($urandom_range(2))
               0: add_pct = 85;
               1: add_pct = 15;
               default: add_pct = 50;
            endcase
         end
         phase_left--;
         if ($urandom_range(99) < 5) begin
            op  = isl_pkg::op_type'($urandom_range(3));
            pos = $urandom_range(127);
         end else if ($urandom_range(99) < add_pct) begin
            op = ($urandom_range(1) == 0) ? isl_pkg::OP_PUSH : isl_pkg::OP_INSERT;
            pos = ($urandom_range(9) == 0) ? $urandom_range(127) : $urandom_range(gen_len);
         end else begin
            op = ($urandom_range(1) == 0) ? isl_pkg::OP_POP : isl_pkg::OP_REMOVE;
            if (gen_len == 0 || $urandom_range(9) == 0)
               pos = $urandom_range(127);
            else
               pos = $urandom_range(gen_len - 1);
         end
         add_req(op, pick_value(), pos);
         case (op)
            isl_pkg::OP_PUSH:   if (gen_len < CAP) gen_len++;
            isl_pkg::OP_POP:    if (gen_len > 0) gen_len--;
            isl_pkg::OP_INSERT: if (pos <= gen_len && gen_len < CAP) gen_len++;
            default:            if (gen_len > 0 && pos < gen_len) gen_len--;
         endcase
      end
   endtask

   // Driver: new transaction or idle at the falling edge, hold while not taken.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && !req_taken)) begin
         if (pending_req.size() > 0 &&
             ((accepted_total >= 300 && accepted_total < 420) ||
              $urandom_range(99) >= IDLE_PCT)) begin
            start        <= 1'b1;
            req_op       <= pending_req[0].op;
            req_value    <= pending_req[0].value;
            req_position <= pending_req[0].position;
            void'(pending_req.pop_front());
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check responses, then predict for the transaction taken this edge.
   always @(posedge clock) begin
      rsp_item_type want;
      req_item_type r;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Verification failed");
         $finish;
      end else if (!reset) begin
         req_taken <= start && !busy;
         if (rsp_valid) begin
            if (expected_rsp.size() == 0) begin
               $display("MISMATCH: response with no request outstanding");
               error_count++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_taken !== want.taken)
                  report_mismatch("taken", rsp_taken, want.taken);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_count !== want.count)
                  report_mismatch("count", rsp_count, want.count);
               status_hits[want.status]++;
            end
            checked_total++;
         end
         if (start && !busy) begin
            r.op       = isl_pkg::op_type'(req_op);
            r.value    = req_value;
            r.position = req_position;
            op_hits[r.op]++;
            expected_rsp.push_back(list_apply(r));
            if (model_len > peak_len) peak_len = model_len;
            accepted_total++;
         end
      end else begin
         req_taken <= 1'b0;
      end
   end

   initial begin
      // directed: empty-list errors, range errors, extremes, both ends
      add_req(isl_pkg::OP_POP,    32'sd0, 0);
      add_req(isl_pkg::OP_REMOVE, 32'sd0, 0);
      add_req(isl_pkg::OP_REMOVE, 32'sd0, 127);
      add_req(isl_pkg::OP_INSERT, 32'sd5, 1);
      add_req(isl_pkg::OP_INSERT, 32'sd5, 127);
      add_req(isl_pkg::OP_INSERT, 32'sh8000_0000, 0);
      add_req(isl_pkg::OP_PUSH,   32'sh7FFF_FFFF, 0);
      add_req(isl_pkg::OP_PUSH,   -32'sd1, 64);
      add_req(isl_pkg::OP_INSERT, 32'sd0, 3);
      add_req(isl_pkg::OP_INSERT, 32'sh5A5A_5A5A, 1);
      add_req(isl_pkg::OP_REMOVE, 32'sd0, 5);
      add_req(isl_pkg::OP_REMOVE, 32'sd0, 127);
      add_req(isl_pkg::OP_INSERT, 32'sd9, 6);
      add_req(isl_pkg::OP_REMOVE, 32'sd0, 0);
      add_req(isl_pkg::OP_REMOVE, 32'sd0, 3);
      add_req(isl_pkg::OP_POP,    32'sd0, 0);
      add_req(isl_pkg::OP_INSERT, -32'sd77, 0);
      add_req(isl_pkg::OP_PUSH,   32'shA5A5_A5A5, 0);
      add_req(isl_pkg::OP_REMOVE, 32'sd0, 2);
      add_req(isl_pkg::OP_PUSH,   32'sd1234, 0);
      build_random();

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (accepted_total == total_items && expected_rsp.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d transactions: push %0d, pop %0d, insert %0d, remove %0d",
               accepted_total, op_hits[isl_pkg::OP_PUSH], op_hits[isl_pkg::OP_POP],
               op_hits[isl_pkg::OP_INSERT], op_hits[isl_pkg::OP_REMOVE]);
      $display("Peak length %0d; ok %0d, full %0d, empty %0d, out of range %0d; mismatches %0d",
               peak_len, status_hits[isl_pkg::ST_OK], status_hits[isl_pkg::ST_FULL],
               status_hits[isl_pkg::ST_EMPTY], status_hits[isl_pkg::ST_RANGE],
               error_count);
      if (error_count == 0 && expected_rsp.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
sv/isl_pkg.sv
sv/isl_datapath.sv
sv/isl_ctrl.sv
sv/indexed_shift_list.sv
tb/sv/tb_top.sv
